[sv/mix_pkg.sv]
package mix_pkg;

    // fixed sizes of the item fields
    localparam int MAX_SLOTS  = 8;
    localparam int SAMPLE_W   = 16;
    localparam int LEN_W      = 24;
    localparam int SLOT_IDX_W = 3;

    // defaults for the top level parameters
    localparam int DEF_SLOTS     = 8;
    localparam int DEF_POS_WIDTH = 24;

    // operation codes
    localparam logic OP_PLAY = 1'b0;
    localparam logic OP_MIX  = 1'b1;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    // clip limits
    localparam sample_t SAMPLE_MAX = 16'h7fff;
    localparam sample_t SAMPLE_MIN = 16'h8000;

    // command item
    typedef struct packed {
        logic                  op;
        logic [LEN_W-1:0]      play_length;
        logic                  play_loop;
        sample_t               sample_0;
        sample_t               sample_1;
        sample_t               sample_2;
        sample_t               sample_3;
        sample_t               sample_4;
        sample_t               sample_5;
        sample_t               sample_6;
        sample_t               sample_7;
    } mix_cmd_t;

    // result item
    typedef struct packed {
        sample_t               mixed_sample;
        logic [MAX_SLOTS-1:0]  active_mask;
        logic [SLOT_IDX_W-1:0] granted_slot;
        logic                  play_accepted;
        logic [LEN_W-1:0]      read_pos_0;
        logic [LEN_W-1:0]      read_pos_1;
        logic [LEN_W-1:0]      read_pos_2;
        logic [LEN_W-1:0]      read_pos_3;
        logic [LEN_W-1:0]      read_pos_4;
        logic [LEN_W-1:0]      read_pos_5;
        logic [LEN_W-1:0]      read_pos_6;
        logic [LEN_W-1:0]      read_pos_7;
    } mix_result_t;

    // item as it travels down the slot chain, result built up cell by cell
    typedef struct packed {
        logic                             op;
        logic [LEN_W-1:0]                 play_length;
        logic                             play_loop;
        sample_t [MAX_SLOTS-1:0]          samples;
        sample_t                          acc;
        logic [SLOT_IDX_W-1:0]            granted_slot;
        logic                             play_accepted;
        logic [MAX_SLOTS-1:0]             active_mask;
        logic [MAX_SLOTS-1:0][LEN_W-1:0]  read_pos;
    } mix_stage_t;

endpackage

[sv/mix_slot_cell.sv]
module mix_slot_cell #(
    parameter int IDX       = 0,
    parameter int POS_WIDTH = mix_pkg::DEF_POS_WIDTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               prev_valid,
    input  mix_pkg::mix_stage_t prev,
    output logic               ready,
    output logic               stage_valid,
    output mix_pkg::mix_stage_t stage,
    input  logic               next_ready
);
    import mix_pkg::*;

    logic                   active_reg, active_next;
    logic                   loop_reg, loop_next;
    logic [POS_WIDTH-1:0]   len_reg, len_next;
    logic [POS_WIDTH-1:0]   pos_reg, pos_next;
    logic                   valid_reg;
    mix_stage_t             stage_reg, stage_next;
    logic                   take;
    logic [POS_WIDTH-1:0]   req_len;
    logic [POS_WIDTH:0]     pos_inc;
    sample_t                smp;
    logic signed [SAMPLE_W:0] sum;

    // handshake with neighbors
    always_comb
    begin
        ready = !valid_reg || next_ready;
        take  = prev_valid && ready;
    end

    // slot update and hand-off to the next cell
    always_comb
    begin
        active_next = active_reg;
        loop_next   = loop_reg;
        len_next    = len_reg;
        pos_next    = pos_reg;
        stage_next  = prev;
        req_len     = POS_WIDTH'(prev.play_length);
        pos_inc     = (POS_WIDTH+1)'(pos_reg) + (POS_WIDTH+1)'(1);
        smp         = prev.samples[IDX];
        sum         = {prev.acc[SAMPLE_W-1], prev.acc} + {smp[SAMPLE_W-1], smp};
        if (prev.op == OP_PLAY)
        begin
            // lowest free slot wins: only claim if no earlier cell did
            if (req_len != '0 && !prev.play_accepted && !active_reg)
            begin
                active_next              = 1'b1;
                loop_next                = prev.play_loop;
                len_next                 = req_len;
                pos_next                 = '0;
                stage_next.play_accepted = 1'b1;
                stage_next.granted_slot  = SLOT_IDX_W'(IDX);
            end
        end
        else if (active_reg)
        begin
            // saturating accumulate
            if (sum > $signed({SAMPLE_MAX[SAMPLE_W-1], SAMPLE_MAX}))
                stage_next.acc = SAMPLE_MAX;
            else if (sum < $signed({SAMPLE_MIN[SAMPLE_W-1], SAMPLE_MIN}))
                stage_next.acc = SAMPLE_MIN;
            else
                stage_next.acc = sum[SAMPLE_W-1:0];
            // advance, wrap or end
            if (pos_inc >= {1'b0, len_reg})
            begin
                pos_next    = '0;
                active_next = loop_reg;
            end
            else
            begin
                pos_next = pos_inc[POS_WIDTH-1:0];
            end
        end
        stage_next.active_mask[IDX] = active_next;
        stage_next.read_pos[IDX]    = LEN_W'(pos_next);
    end

    // slot state and control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            loop_reg   <= 1'b0;
            len_reg    <= '0;
            pos_reg    <= '0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                active_reg <= active_next;
                loop_reg   <= loop_next;
                len_reg    <= len_next;
                pos_reg    <= pos_next;
            end
            if (ready)
                valid_reg <= prev_valid;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (take)
            stage_reg <= stage_next;
    end

    assign stage_valid = valid_reg;
    assign stage       = stage_reg;

endmodule

[sv/multi_slot_saturating_audio_mixer_core.sv]
// channel  | valid         | stall         | payload
// ---------+---------------+---------------+-------------------------
// command  | cmd_valid     | cmd_stall     | cmd    (mix_cmd_t)
// result   | result_valid  | result_stall  | result (mix_result_t)
//
// one item per cycle; each item walks the row of slot cells, one cell a cycle when not stalled,
// so its result comes out of the register of the last cell
// each cell updates its own slot as the item passes, which keeps items in order
// reset clears all slots (inactive, length and position zero) at once
// a stalled result holds only the cells behind it that are full; empty cells keep moving
module multi_slot_saturating_audio_mixer_core #(
    parameter int SLOTS     = mix_pkg::DEF_SLOTS,
    parameter int POS_WIDTH = mix_pkg::DEF_POS_WIDTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    output logic                 cmd_stall,
    input  mix_pkg::mix_cmd_t    cmd,
    output logic                 result_valid,
    input  logic                 result_stall,
    output mix_pkg::mix_result_t result
);
    import mix_pkg::*;

    mix_stage_t chain       [SLOTS+1];
    logic       chain_valid [SLOTS+1];
    logic       chain_ready [SLOTS+1];
    mix_stage_t last;

    // item enters the chain with an empty result
    always_comb
    begin
        chain[0]               = '0;
        chain[0].op            = cmd.op;
        chain[0].play_length   = cmd.play_length;
        chain[0].play_loop     = cmd.play_loop;
        chain[0].samples[0]    = cmd.sample_0;
        chain[0].samples[1]    = cmd.sample_1;
        chain[0].samples[2]    = cmd.sample_2;
        chain[0].samples[3]    = cmd.sample_3;
        chain[0].samples[4]    = cmd.sample_4;
        chain[0].samples[5]    = cmd.sample_5;
        chain[0].samples[6]    = cmd.sample_6;
        chain[0].samples[7]    = cmd.sample_7;
    end

    assign chain_valid[0]     = cmd_valid;
    assign cmd_stall          = !chain_ready[0];
    assign chain_ready[SLOTS] = !result_stall;

    // row of slot cells
    for (genvar k = 0; k < SLOTS; k++)
    begin : g_cell
        mix_slot_cell #(
            .IDX       (k),
            .POS_WIDTH (POS_WIDTH)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .prev_valid  (chain_valid[k]),
            .prev        (chain[k]),
            .ready       (chain_ready[k]),
            .stage_valid (chain_valid[k+1]),
            .stage       (chain[k+1]),
            .next_ready  (chain_ready[k+1])
        );
    end

    // last cell register is the result register
    assign last         = chain[SLOTS];
    assign result_valid = chain_valid[SLOTS];

    always_comb
    begin
        result.mixed_sample  = last.acc;
        result.active_mask   = last.active_mask;
        result.granted_slot  = last.granted_slot;
        result.play_accepted = last.play_accepted;
        result.read_pos_0    = last.read_pos[0];
        result.read_pos_1    = last.read_pos[1];
        result.read_pos_2    = last.read_pos[2];
        result.read_pos_3    = last.read_pos[3];
        result.read_pos_4    = last.read_pos[4];
        result.read_pos_5    = last.read_pos[5];
        result.read_pos_6    = last.read_pos[6];
        result.read_pos_7    = last.read_pos[7];
    end

    // an empty result register never holds back the command side
    assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> !cmd_stall)
        else $error("command stalled with no result pending");

    // a granted slot shows as active in the same result
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.play_accepted) |-> result.active_mask[result.granted_slot])
        else $error("granted slot not active");

    // play items carry no mixed sample
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.play_accepted) |-> (result.mixed_sample == '0))
        else $error("play item with nonzero mixed sample");

    // slots beyond the configured count never become active
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ((MAX_SLOTS'(result.active_mask) >> SLOTS) == '0))
        else $error("mask bit set above slot count");

endmodule
